[hw/rtl/xsbr_pkg.sv]
package xsbr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned DWORD_W = 64;
  localparam int unsigned CMD_W = 2;

  localparam logic [WORD_W-1:0] SEED_RESET = 32'd2463534242;

  localparam logic [CMD_W-1:0] CMD_RANGE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RAW64 = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RAW32 = 2'd2;

  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 17;
  localparam int unsigned SHIFT_C = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [DWORD_W-1:0] dword_t;

  // Status handed back by the shared remainder unit.
  typedef struct packed {
    logic   done;
    dword_t rem;
  } rem_status_t;

endpackage

[hw/rtl/xsbr_xorshift.sv]
module xsbr_xorshift
  import xsbr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  word_t seed,
  input  logic  step,
  output word_t next_value
);

  word_t state_r;
  word_t state_nxt;
  word_t s1;
  word_t s2;

  always_comb begin
    s1 = state_r ^ (state_r << SHIFT_A);
    s2 = s1 ^ (s1 >> SHIFT_B);
    next_value = s2 ^ (s2 << SHIFT_C);
  end

  always_comb begin
    state_nxt = state_r;
    if (load) begin
      state_nxt = seed;
    end else if (step) begin
      state_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEED_RESET;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/xsbr_remainder.sv]
module xsbr_remainder
  import xsbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  dword_t      dividend,
  input  dword_t      divisor,
  output rem_status_t status
);

  localparam int unsigned CNT_W = $clog2(DWORD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  dword_t           rem_r, rem_nxt;
  dword_t           quo_r, quo_nxt;
  dword_t           div_r, div_nxt;
  logic [DWORD_W:0] trial;
  logic [DWORD_W:0] diff;

  // One quotient bit per cycle: shift in the next dividend bit and subtract
  // the divisor where it fits.
  always_comb begin
    trial = {rem_r, quo_r[DWORD_W-1]};
    diff = trial - {1'b0, div_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    div_nxt = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '1;
      rem_nxt = '0;
      quo_nxt = dividend;
      div_nxt = divisor;
    end else if (busy_r) begin
      quo_nxt = quo_r << 1;
      if (!diff[DWORD_W]) begin
        rem_nxt = diff[DWORD_W-1:0];
      end else begin
        rem_nxt = trial[DWORD_W-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign status.done = done_r;
  assign status.rem = rem_r;

endmodule

[hw/rtl/xorshift_bounded_random_top.sv]
// Channel  | Direction | Handshake            | Payload
// in       | input     | in_valid / in_ready   | in_cmd, in_range_min, in_range_max
// out      | output    | out_valid / out_ready | out_value
// cfg      | input     | APB psel / penable    | paddr, pwdata, prdata
//
// From acceptance, a raw 32-bit item draws one generator word and a raw 64-bit item draws two.
// A range item runs setup, a first pass of the one bit-serial remainder unit, draw and check,
// a second pass and finish; each rejected 64-bit draw goes back to draw again.
// A full-range item skips both passes. A new item can be taken in the cycle after
// a result is registered. Reset is synchronous and active low; it loads the seed register and
// the generator state with the reset seed. A finished item waits in the output register while
// the next is accepted; while that register is full the next result keeps the block busy.
module xorshift_bounded_random_top
  import xsbr_pkg::*;
#(
  parameter int unsigned ADDR_W = 3
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic signed [63:0]   in_range_min,
  input  logic signed [63:0]   in_range_max,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          out_value,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [WORD_W-1:0]    pwdata,
  output logic [WORD_W-1:0]    prdata,
  output logic                 pready
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PREP    = 3'd1;
  localparam logic [2:0] S_DIV_M   = 3'd2;
  localparam logic [2:0] S_DRAW_HI = 3'd3;
  localparam logic [2:0] S_DRAW_LO = 3'd4;
  localparam logic [2:0] S_CHECK   = 3'd5;
  localparam logic [2:0] S_DIV_R   = 3'd6;
  localparam logic [2:0] S_FINISH  = 3'd7;

  localparam logic [ADDR_W-1:0] REG_SEED = '0;

  logic [2:0]       state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  dword_t           min_r, min_nxt;
  dword_t           n_r, n_nxt;
  dword_t           m_r, m_nxt;
  dword_t           r_r, r_nxt;
  logic             full_r, full_nxt;
  logic             mzero_r, mzero_nxt;
  logic             out_valid_r, out_valid_nxt;
  dword_t           out_value_r, out_value_nxt;
  word_t            seed_r;

  logic        cfg_write;
  logic        gen_step;
  word_t       gen_next;
  logic        div_start;
  dword_t      div_dividend;
  rem_status_t div_status;
  dword_t      result;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == REG_SEED);
  assign prdata = (paddr == REG_SEED) ? seed_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_write) begin
      seed_r <= pwdata;
    end
  end

  assign gen_step = (state_r == S_DRAW_HI) || (state_r == S_DRAW_LO);

  xsbr_xorshift u_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (cfg_write),
    .seed       (pwdata),
    .step       (gen_step),
    .next_value (gen_next)
  );

  // The first pass finds 2^64 mod n from (0 - n) mod n; the second reduces
  // the accepted draw.
  assign div_dividend = (state_r == S_PREP) ? (dword_t'(0) - n_r) : r_r;

  xsbr_remainder u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_r),
    .status   (div_status)
  );

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  always_comb begin
    priority if (cmd_r == CMD_RANGE) begin
      result = (full_r ? r_r : div_status.rem) + min_r;
    end else if (cmd_r == CMD_RAW64) begin
      result = r_r;
    end else begin
      result = {{(DWORD_W-WORD_W){1'b0}}, r_r[WORD_W-1:0]};
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    min_nxt = min_r;
    n_nxt = n_r;
    m_nxt = m_r;
    r_nxt = r_r;
    full_nxt = full_r;
    mzero_nxt = mzero_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_cmd;
          min_nxt = in_range_min;
          n_nxt = dword_t'(in_range_max - in_range_min + 64'sd1);
          r_nxt = '0;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        full_nxt = (n_r == '0);
        priority if (cmd_r == CMD_RANGE && n_r != '0) begin
          div_start = 1'b1;
          state_nxt = S_DIV_M;
        end else if (cmd_r == CMD_RANGE || cmd_r == CMD_RAW64) begin
          state_nxt = S_DRAW_HI;
        end else begin
          state_nxt = S_DRAW_LO;
        end
      end
      S_DIV_M: begin
        if (div_status.done) begin
          m_nxt = dword_t'(0) - div_status.rem;
          mzero_nxt = (div_status.rem == '0);
          state_nxt = S_DRAW_HI;
        end
      end
      S_DRAW_HI: begin
        r_nxt[DWORD_W-1:WORD_W] = gen_next;
        state_nxt = S_DRAW_LO;
      end
      S_DRAW_LO: begin
        r_nxt[WORD_W-1:0] = gen_next;
        state_nxt = (cmd_r == CMD_RANGE && !full_r) ? S_CHECK : S_FINISH;
      end
      S_CHECK: begin
        // A limit of zero means a power-of-two range: every draw is kept.
        if (mzero_r || (r_r < m_r)) begin
          div_start = 1'b1;
          state_nxt = S_DIV_R;
        end else begin
          state_nxt = S_DRAW_HI;
        end
      end
      S_DIV_R: begin
        if (div_status.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = result;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    min_r <= min_nxt;
    n_r <= n_nxt;
    m_r <= m_nxt;
    r_r <= r_nxt;
    full_r <= full_nxt;
    mzero_r <= mzero_nxt;
    out_value_r <= out_value_nxt;
  end

endmodule

[tb/xsbr_tb_pkg.sv]
`timescale 1ns / 100ps
package xsbr_tb_pkg;

  localparam int unsigned CFG_ADDR_W = 3;

  // The seed is the only register, at byte address zero.
  localparam logic [CFG_ADDR_W-1:0] REG_SEED_ADDR = 3'd0;

  // Selector value with no command of its own: it serves a raw 32-bit draw.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

endpackage

[tb/xsbr_checker.sv]
`timescale 1ns / 100ps
module xsbr_checker
  import xsbr_pkg::*;
  import xsbr_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [63:0]           in_range_min,
  input  logic [63:0]           in_range_max,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [63:0]           out_value,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0]     pwdata,
  input  logic [WORD_W-1:0]     prdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending,
  output int                    results_seen,
  output int                    redraws
);

  typedef struct {
    logic [CMD_W-1:0] cmd;
    dword_t           value;
  } draw_rec_t;

  draw_rec_t owed_q[$];
  word_t     seed_copy;
  word_t     gen_state;
  int        fails;
  int        seen;
  int        redraw_tally;

  function automatic word_t next_word();
    word_t x;
    x = gen_state;
    x ^= x << SHIFT_A;
    x ^= x >> SHIFT_B;
    x ^= x << SHIFT_C;
    gen_state = x;
    return x;
  endfunction

  function automatic dword_t next_pair();
    word_t hi_word;
    word_t lo_word;
    hi_word = next_word();
    lo_word = next_word();
    return {hi_word, lo_word};
  endfunction

  // Uniform draw from [lo, hi] by rejection; all arithmetic wraps at 64 bits.
  function automatic dword_t draw_bounded(dword_t lo, dword_t hi);
    dword_t span;
    dword_t accept_lim;
    dword_t r;
    span = hi - lo + 64'd1;
    if (span == 64'd0) return next_pair() + lo;
    accept_lim = 64'd0 - ((64'd0 - span) % span);
    r = next_pair();
    if (accept_lim != 64'd0) begin
      while (r >= accept_lim) begin
        r = next_pair();
        redraw_tally++;
      end
    end
    return (r % span) + lo;
  endfunction

  function automatic dword_t predict_item(logic [CMD_W-1:0] cmd, dword_t lo, dword_t hi);
    case (cmd)
      CMD_RANGE: return draw_bounded(lo, hi);
      CMD_RAW64: return next_pair();
      default:   return {32'd0, next_word()};
    endcase
  endfunction

  initial begin
    fails = 0;
    seen = 0;
    redraw_tally = 0;
  end

  always @(posedge clk) begin : track
    draw_rec_t want;
    if (!rst_n) begin
      seed_copy = SEED_RESET;
      gen_state = SEED_RESET;
      owed_q.delete();
    end else begin
      // Results are retired before new items are queued, so an item never
      // pairs with a result that leaves on the edge at which it arrives.
      if (out_valid && out_ready) begin
        seen++;
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_value);
          fails++;
        end else begin
          want = owed_q.pop_front();
          if (out_value !== want.value) begin
            $display("%0t: value mismatch on cmd %0d, expected %h actual %h",
                     $time, want.cmd, want.value, out_value);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want.cmd = in_cmd;
        want.value = predict_item(in_cmd, in_range_min, in_range_max);
        owed_q.push_back(want);
      end
      if (psel && penable && pready && paddr == REG_SEED_ADDR) begin
        if (pwrite) begin
          seed_copy = pwdata;
          gen_state = pwdata;
        end else if (prdata !== seed_copy) begin
          $display("%0t: seed read mismatch, expected %h actual %h",
                   $time, seed_copy, prdata);
          fails++;
        end
      end
    end
    fail_count <= fails;
    pending <= owed_q.size();
    results_seen <= seen;
    redraws <= redraw_tally;
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
module tb;
  import xsbr_pkg::*;
  import xsbr_tb_pkg::*;

  localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] HALF_SPAN = 64'h8000_0000_0000_0000;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 200;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_cmd = CMD_RAW32;
  logic [63:0]           in_range_min = 64'd0;
  logic [63:0]           in_range_max = 64'd0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [63:0]           out_value;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = REG_SEED_ADDR;
  logic [WORD_W-1:0]     pwdata = '0;
  logic [WORD_W-1:0]     prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int results_seen;
  int redraws;

  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned rand_count = 0;
  int unsigned seeds_set = 0;
  int unsigned cycle_count = 0;

  xorshift_bounded_random_top #(
    .ADDR_W(CFG_ADDR_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_range_min (in_range_min),
    .in_range_max (in_range_max),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  xsbr_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_range_min (in_range_min),
    .in_range_max (in_range_max),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .redraws      (redraws)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run timed out after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: occasional stalls, plus one long hold-off so that the block
  // fills up and has to refuse new items.
  initial begin : receiver
    int unsigned held_cycles;
    bit          held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        held_cycles = 0;
        while (held_cycles < HOLD_CYCLES) begin
          @(posedge clk);
          held_cycles++;
        end
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 6);
      end
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [63:0] lo,
                           input logic [63:0] hi);
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_range_min <= lo;
    in_range_max <= hi;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic apb_access(input logic wr, input word_t data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= REG_SEED_ADDR;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Each write is read straight back; the checker compares the read data.
  task automatic load_seed(input word_t s);
    apb_access(1'b1, s);
    apb_access(1'b0, '0);
    seeds_set++;
  endtask

  task automatic pick_item(output logic [CMD_W-1:0] c, output logic [63:0] lo,
                           output logic [63:0] hi);
    int unsigned roll;
    int unsigned shape;
    logic [63:0] tmp;
    roll = $urandom_range(99);
    if (roll < 45) c = CMD_RANGE;
    else if (roll < 70) c = CMD_RAW64;
    else if (roll < 90) c = CMD_RAW32;
    else c = CMD_UNUSED;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    if (c == CMD_RANGE) begin
      shape = $urandom_range(99);
      if (shape < 30) begin
        if ($urandom_range(1) == 1) lo = longint'($urandom_range(2000)) - 1000;
        hi = lo + 64'($urandom_range(1000));
      end else if (shape < 45) begin
        hi = lo + (64'd1 << $urandom_range(63)) - 64'd1;
      end else if (shape < 57) begin
        // Spans just above half the draw space reject up to half the draws.
        hi = lo + HALF_SPAN + ({$urandom, $urandom} >> 2);
      end else if (shape < 65) begin
        if ($urandom_range(3) == 0) begin
          lo = INT64_MIN;
          hi = INT64_MAX;
        end else begin
          hi = lo - 64'd1;
        end
      end else if (shape < 78) begin
        if ($signed(hi) > $signed(lo)) begin
          tmp = hi;
          hi = lo;
          lo = tmp;
        end
      end
    end
  endtask

  task automatic run_random(input int unsigned count);
    logic [CMD_W-1:0] c;
    logic [63:0]      lo;
    logic [63:0]      hi;
    for (int unsigned k = 0; k < count; k++) begin
      rand_count++;
      if (rand_count == 120) hold_req <= 1'b1;
      if (rand_count == 300) drain();
      if (rand_count == 400) quiet <= 1'b1;
      if (rand_count == 520) quiet <= 1'b0;
      pick_item(c, lo, hi);
      send_item(c, lo, hi);
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apb_access(1'b0, '0);

    // Reset seed: every command and the awkward ranges.
    send_item(CMD_RAW32, 64'd0, 64'd0);
    send_item(CMD_RAW64, '1, '1);
    send_item(CMD_UNUSED, INT64_MIN, INT64_MAX);
    send_item(CMD_RANGE, 64'd0, 64'd9);
    send_item(CMD_RANGE, -64'sd5, 64'd5);
    send_item(CMD_RANGE, 64'd42, 64'd42);
    send_item(CMD_RANGE, INT64_MIN, INT64_MAX);
    send_item(CMD_RANGE, 64'd100, 64'd99);
    send_item(CMD_RANGE, 64'd0, 64'd255);
    send_item(CMD_RANGE, 64'hC000_0000_0000_0000, 64'h3FFF_FFFF_FFFF_FFFF);
    send_item(CMD_RANGE, 64'd10, 64'd3);
    send_item(CMD_RANGE, 64'd0, HALF_SPAN);
    send_item(CMD_RANGE, INT64_MIN, INT64_MIN);
    send_item(CMD_RANGE, INT64_MAX, INT64_MAX);
    send_item(CMD_RANGE, INT64_MAX, INT64_MIN);
    send_item(CMD_RANGE, '1, 64'd0);
    send_item(CMD_RANGE, INT64_MIN, '1);
    send_item(CMD_RANGE, -64'sd3, INT64_MAX);
    send_item(CMD_RANGE, '1, '1);
    drain();

    // A zero seed pins every draw at zero, so range items give their minimum.
    load_seed('0);
    send_item(CMD_RANGE, 64'd7, HALF_SPAN + 64'd7);
    send_item(CMD_RAW64, 64'd0, 64'd0);
    send_item(CMD_RAW32, 64'd0, 64'd0);
    send_item(CMD_RANGE, INT64_MIN + 64'd5, INT64_MIN + 64'd4);
    drain();

    load_seed('1);
    run_random(160);
    drain();
    load_seed(32'd1);
    run_random(160);
    drain();
    load_seed($urandom);
    run_random(160);
    drain();
    load_seed($urandom);
    run_random(150);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d items under %0d seed settings, %0d results compared",
             items_sent, seeds_set, results_seen);
    $display("Range mode redrew %0d rejected 64-bit values", redraws);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
